[hdl/source_text_tokenizer_macros.svh]
// ----------------------------------------------------------------------------
// source_text_tokenizer_macros
// assertion helpers for the tokenizer, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

// condition holds on every clock edge outside reset
`define STT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define STT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg
// types, constants and character helpers of the source text tokenizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stt_pkg;

    localparam int MAX_TOKEN_LEN = 32;
    // kept characters per token
    localparam int TEXT_CAP = ((MAX_TOKEN_LEN - 1) < 31) ? (MAX_TOKEN_LEN - 1) : 31;
    localparam int ADDR_W   = (TEXT_CAP > 1) ? $clog2(TEXT_CAP) : 1;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_DIGITS,
        MODE_LETTERS,
        MODE_QUOTED,
        MODE_EQUAL
    } t_mode;

    typedef enum logic [3:0] {
        K_END     = 4'd0,
        K_INT     = 4'd1,
        K_STRING  = 4'd2,
        K_BOOL    = 4'd3,
        K_IDENT   = 4'd4,
        K_KEYWORD = 4'd5,
        K_BINOP   = 4'd6,
        K_EQUALS  = 4'd7,
        K_COMPARE = 4'd8,
        K_IF      = 4'd9,
        K_ELSE    = 4'd10,
        K_LPAREN  = 4'd11,
        K_RPAREN  = 4'd12,
        K_SEMI    = 4'd13,
        K_LCURLY  = 4'd14,
        K_RCURLY  = 4'd15
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MEM,
        S_SMALL
    } t_state;

    // token whose text is a repeated constant character (cnt 0 means no text)
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  chr;
        logic [1:0]  cnt;
    } t_small;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  chr;
        logic        cv;
        logic [4:0]  idx;
        logic        lot;
        logic        trunc;
        logic        last;
    } t_result;

    // reserved words, one row each, zero padded
    localparam int KW_N     = 7;
    localparam int KW_INT   = 0;
    localparam int KW_STR   = 1;
    localparam int KW_BOOL  = 2;
    localparam int KW_TRUE  = 3;
    localparam int KW_FALSE = 4;
    localparam int KW_IF    = 5;
    localparam int KW_ELSE  = 6;

    localparam logic [7:0] KW_CHR [KW_N][8] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "t", "r", "i", "n", "g", 8'h00, 8'h00},
        '{"b", "o", "o", "l", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [KW_N] = '{3'd3, 3'd6, 3'd4, 3'd4, 3'd5, 3'd2, 3'd4};

    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    // kind of a byte that forms a token on its own
    function automatic t_kind single_kind(input logic [7:0] c);
        t_kind k;
        case (c)
            "+", "-", "*", "/": k = K_BINOP;
            "(":                k = K_LPAREN;
            ")":                k = K_RPAREN;
            ";":                k = K_SEMI;
            "{":                k = K_LCURLY;
            "}":                k = K_RCURLY;
            "<", ">":           k = K_COMPARE;
            default:            k = K_IDENT;
        endcase
        return k;
    endfunction

    // true where the single-byte token ends a pending declaration
    function automatic logic single_clears(input logic [7:0] c);
        return c inside {"+", "-", "*", "/", "(", ")", ";"};
    endfunction

endpackage

[hdl/source_text_tokenizer.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer: byte-serial lexer, one result beat per token character,
//   or one beat without text for a token that has none; a stored token leaves
//   through the registered read port of the text memory
// input waits while a token leaves, so no new byte is taken before then
// reset: i_rst_n synchronous, active low; clears scan state and output, not text
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "source_text_tokenizer_macros.svh"

module source_text_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // char_byte, char_index, token_truncated, last
    output logic [4:0]  m_axis_tuser,   // token_kind, char_valid
    output logic        m_axis_tlast    // last_of_token
);

    localparam logic [4:0] CAP5 = 5'(stt_pkg::TEXT_CAP);

    // scan state
    stt_pkg::t_mode              r_mode, n_mode;
    logic [7:0]                  r_quote, n_quote;
    logic [4:0]                  r_len, n_len;
    logic                        r_expect, n_expect;
    logic                        r_ovf, n_ovf;
    logic [stt_pkg::KW_N-1:0]    r_kw, n_kw;

    // token text memory and its deferred write
    logic [7:0]                  mem_text [stt_pkg::TEXT_CAP];
    logic [7:0]                  r_rd_data;
    logic                        r_wr_pend, n_wr_pend;
    logic [stt_pkg::ADDR_W-1:0]  r_wr_addr;
    logic [7:0]                  r_wr_data;
    logic                        mem_wr;
    logic                        rd_issue;

    // plan of the accepted byte
    logic                        p_wr;
    logic [stt_pkg::ADDR_W-1:0]  p_wr_addr;
    logic                        p_do_mem;
    stt_pkg::t_kind              p_mem_kind;
    logic                        p_do_a, p_do_b;
    stt_pkg::t_small             p_a, p_b, tok;
    logic                        flush, restart, app, s_exp;
    logic [stt_pkg::KW_N-1:0]    kw_app, kw_first, kw_hit;

    // emission sequencer
    stt_pkg::t_state             r_state, n_state;
    stt_pkg::t_kind              r_mem_kind, n_mem_kind;
    logic [4:0]                  r_mem_len, n_mem_len;
    logic                        r_mem_trunc, n_mem_trunc;
    logic                        r_do_a, n_do_a, r_do_b, n_do_b;
    stt_pkg::t_small             r_a, n_a, r_b, n_b;
    logic [4:0]                  r_ri, n_ri, r_ci, n_ci;
    logic                        r_dv, n_dv;
    logic                        r_si, n_si;
    logic                        acc, adv, consume, emit, lot;
    stt_pkg::t_result            res, r_out;
    logic                        r_o_valid;

    assign s_axis_tready = (r_state == stt_pkg::S_IDLE);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign adv           = !r_o_valid || m_axis_tready;
    assign mem_wr        = r_wr_pend && (r_state != stt_pkg::S_MEM);

    // reserved word tracking, one match bit per word
    always_comb begin
        for (int w = 0; w < stt_pkg::KW_N; w++) begin
            kw_app[w]   = (r_len < {2'b00, stt_pkg::KW_LEN[w]}) &&
                          (s_axis_tdata == stt_pkg::KW_CHR[w][r_len[2:0]]);
            kw_first[w] = (s_axis_tdata == stt_pkg::KW_CHR[w][0]);
            kw_hit[w]   = r_kw[w] && (r_len == {2'b00, stt_pkg::KW_LEN[w]});
        end
    end

    // scanner: next scan state and the token plan for one accepted byte
    always_comb begin
        n_mode     = r_mode;
        n_quote    = r_quote;
        n_len      = r_len;
        n_ovf      = r_ovf;
        n_kw       = r_kw;
        s_exp      = r_expect;
        p_wr       = 1'b0;
        p_wr_addr  = r_len[stt_pkg::ADDR_W-1:0];
        p_do_mem   = 1'b0;
        p_mem_kind = stt_pkg::K_IDENT;
        p_do_a     = 1'b0;
        p_a        = '{stt_pkg::K_END, 8'h00, 2'd0};
        p_do_b     = 1'b0;
        p_b        = '{stt_pkg::K_END, 8'h00, 2'd0};
        tok        = '{stt_pkg::K_END, 8'h00, 2'd0};
        flush      = 1'b0;
        restart    = 1'b0;
        app        = 1'b0;

        if (s_axis_tlast) begin
            case (r_mode)
                stt_pkg::MODE_DIGITS, stt_pkg::MODE_LETTERS: begin
                    flush = 1'b1;
                end
                stt_pkg::MODE_QUOTED: begin
                    p_do_mem   = 1'b1;
                    p_mem_kind = stt_pkg::K_STRING;
                    s_exp      = 1'b0;
                end
                stt_pkg::MODE_EQUAL: begin
                    p_do_a = 1'b1;
                    p_a    = '{stt_pkg::K_EQUALS, stt_pkg::CH_EQ, 2'd1};
                end
                default: ;
            endcase
        end else begin
            case (r_mode)
                stt_pkg::MODE_DIGITS: begin
                    if (stt_pkg::is_digit(s_axis_tdata)) begin
                        app = 1'b1;
                    end else begin
                        flush   = 1'b1;
                        restart = 1'b1;
                    end
                end
                stt_pkg::MODE_LETTERS: begin
                    if (stt_pkg::is_alpha(s_axis_tdata)) begin
                        app = 1'b1;
                    end else begin
                        flush   = 1'b1;
                        restart = 1'b1;
                    end
                end
                stt_pkg::MODE_QUOTED: begin
                    if (s_axis_tdata == r_quote) begin
                        p_do_mem   = 1'b1;
                        p_mem_kind = stt_pkg::K_STRING;
                        s_exp      = 1'b0;
                        n_mode     = stt_pkg::MODE_IDLE;
                        n_len      = 5'd0;
                        n_ovf      = 1'b0;
                    end else begin
                        app = 1'b1;
                    end
                end
                stt_pkg::MODE_EQUAL: begin
                    n_mode = stt_pkg::MODE_IDLE;
                    n_len  = 5'd0;
                    n_ovf  = 1'b0;
                    p_do_a = 1'b1;
                    if (s_axis_tdata == stt_pkg::CH_EQ) begin
                        p_a = '{stt_pkg::K_COMPARE, stt_pkg::CH_EQ, 2'd2};
                    end else begin
                        p_a     = '{stt_pkg::K_EQUALS, stt_pkg::CH_EQ, 2'd1};
                        restart = 1'b1;
                    end
                end
                default: begin
                    restart = 1'b1;
                end
            endcase
        end

        // classify the finished digit or letter run
        if (flush) begin
            p_do_mem = 1'b1;
            if (r_mode == stt_pkg::MODE_DIGITS) begin
                p_mem_kind = stt_pkg::K_INT;
                s_exp      = 1'b0;
            end else if (kw_hit[stt_pkg::KW_INT] || kw_hit[stt_pkg::KW_STR] ||
                         kw_hit[stt_pkg::KW_BOOL]) begin
                p_mem_kind = stt_pkg::K_KEYWORD;
                s_exp      = 1'b1;
            end else if (r_expect) begin
                p_mem_kind = stt_pkg::K_IDENT;
                s_exp      = 1'b0;
            end else if (kw_hit[stt_pkg::KW_TRUE] || kw_hit[stt_pkg::KW_FALSE]) begin
                p_mem_kind = stt_pkg::K_BOOL;
                s_exp      = 1'b0;
            end else if (kw_hit[stt_pkg::KW_IF]) begin
                p_mem_kind = stt_pkg::K_IF;
                s_exp      = 1'b0;
            end else if (kw_hit[stt_pkg::KW_ELSE]) begin
                p_mem_kind = stt_pkg::K_ELSE;
            end else begin
                p_mem_kind = stt_pkg::K_IDENT;
            end
            n_mode = stt_pkg::MODE_IDLE;
            n_len  = 5'd0;
            n_ovf  = 1'b0;
        end

        if (app) begin
            if (r_len < CAP5) begin
                p_wr  = 1'b1;
                n_len = r_len + 5'd1;
                n_kw  = r_kw & kw_app;
            end else begin
                n_ovf = 1'b1;
            end
        end

        // fresh scan of a byte met in idle mode or of the byte that ended the previous token
        if (restart && !stt_pkg::is_space(s_axis_tdata)) begin
            if (stt_pkg::is_digit(s_axis_tdata) || stt_pkg::is_alpha(s_axis_tdata)) begin
                n_mode    = stt_pkg::is_digit(s_axis_tdata) ? stt_pkg::MODE_DIGITS
                                                            : stt_pkg::MODE_LETTERS;
                n_len     = 5'd1;
                n_ovf     = 1'b0;
                p_wr      = 1'b1;
                p_wr_addr = '0;
                n_kw      = kw_first;
            end else if (s_axis_tdata == stt_pkg::CH_EQ) begin
                n_mode = stt_pkg::MODE_EQUAL;
                n_len  = 5'd0;
                n_ovf  = 1'b0;
            end else if (s_axis_tdata == stt_pkg::CH_SQUOTE ||
                         s_axis_tdata == stt_pkg::CH_DQUOTE) begin
                n_mode  = stt_pkg::MODE_QUOTED;
                n_len   = 5'd0;
                n_ovf   = 1'b0;
                n_quote = s_axis_tdata;
                n_kw    = '1;
            end else begin
                tok = '{stt_pkg::single_kind(s_axis_tdata), s_axis_tdata, 2'd1};
                if (stt_pkg::single_clears(s_axis_tdata)) begin
                    s_exp = 1'b0;
                end
                if (p_do_a) begin
                    p_do_b = 1'b1;
                    p_b    = tok;
                end else begin
                    p_do_a = 1'b1;
                    p_a    = tok;
                end
            end
        end

        if (s_axis_tlast) begin
            n_mode = stt_pkg::MODE_IDLE;
            n_len  = 5'd0;
            n_ovf  = 1'b0;
            if (p_do_a) begin
                p_do_b = 1'b1;
                p_b    = '{stt_pkg::K_END, 8'h00, 2'd0};
            end else begin
                p_do_a = 1'b1;
                p_a    = '{stt_pkg::K_END, 8'h00, 2'd0};
            end
        end
        n_expect = s_exp;
    end

    // emission sequencer: stored token, then up to two constant tokens
    always_comb begin
        n_state     = r_state;
        n_mem_kind  = r_mem_kind;
        n_mem_len   = r_mem_len;
        n_mem_trunc = r_mem_trunc;
        n_do_a      = r_do_a;
        n_a         = r_a;
        n_do_b      = r_do_b;
        n_b         = r_b;
        n_ri        = r_ri;
        n_ci        = r_ci;
        n_dv        = r_dv;
        n_si        = r_si;
        consume     = 1'b0;
        rd_issue    = 1'b0;
        emit        = 1'b0;
        lot         = 1'b0;
        res         = r_out;

        case (r_state)
            stt_pkg::S_IDLE: begin
                if (acc) begin
                    n_mem_kind  = p_mem_kind;
                    n_mem_len   = r_len;
                    n_mem_trunc = r_ovf;
                    n_do_a      = p_do_a;
                    n_a         = p_a;
                    n_do_b      = p_do_b;
                    n_b         = p_b;
                    n_ri        = 5'd0;
                    n_ci        = 5'd0;
                    n_dv        = 1'b0;
                    n_si        = 1'b0;
                    if (p_do_mem) begin
                        n_state = stt_pkg::S_MEM;
                    end else if (p_do_a) begin
                        n_state = stt_pkg::S_SMALL;
                    end
                end
            end
            stt_pkg::S_MEM: begin
                if (r_mem_len == 5'd0) begin
                    // empty string: one beat without text
                    if (adv) begin
                        emit = 1'b1;
                        lot  = 1'b1;
                        res  = '{r_mem_kind, 8'h00, 1'b0, 5'd0, 1'b1, r_mem_trunc, !r_do_a};
                    end
                end else begin
                    consume  = r_dv && adv;
                    rd_issue = (r_ri < r_mem_len) && (!r_dv || consume);
                    if (rd_issue) begin
                        n_ri = r_ri + 5'd1;
                    end
                    if (consume) begin
                        emit = 1'b1;
                        lot  = (r_ci == r_mem_len - 5'd1);
                        n_ci = r_ci + 5'd1;
                        res  = '{r_mem_kind, r_rd_data, 1'b1, r_ci, lot, r_mem_trunc,
                                 lot && !r_do_a};
                    end
                    n_dv = rd_issue ? 1'b1 : (consume ? 1'b0 : r_dv);
                end
                if (emit && lot) begin
                    n_si    = 1'b0;
                    n_state = r_do_a ? stt_pkg::S_SMALL : stt_pkg::S_IDLE;
                end
            end
            stt_pkg::S_SMALL: begin
                if (adv) begin
                    emit = 1'b1;
                    lot  = (r_a.cnt == 2'd0) || ({1'b0, r_si} == r_a.cnt - 2'd1);
                    res  = '{r_a.kind, (r_a.cnt == 2'd0) ? 8'h00 : r_a.chr, r_a.cnt != 2'd0,
                             {4'b0000, r_si}, lot, 1'b0, lot && !r_do_b};
                    if (lot) begin
                        n_si = 1'b0;
                        if (r_do_b) begin
                            n_a    = r_b;
                            n_do_b = 1'b0;
                        end else begin
                            n_do_a  = 1'b0;
                            n_state = stt_pkg::S_IDLE;
                        end
                    end else begin
                        n_si = 1'b1;
                    end
                end
            end
            default: begin
                n_state = stt_pkg::S_IDLE;
            end
        endcase
    end

    assign n_wr_pend = (acc && p_wr) ? 1'b1 : (mem_wr ? 1'b0 : r_wr_pend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= stt_pkg::S_IDLE;
            r_mode    <= stt_pkg::MODE_IDLE;
            r_quote   <= 8'h00;
            r_len     <= 5'd0;
            r_expect  <= 1'b0;
            r_ovf     <= 1'b0;
            r_kw      <= '1;
            r_wr_pend <= 1'b0;
            r_do_a    <= 1'b0;
            r_do_b    <= 1'b0;
            r_ri      <= 5'd0;
            r_ci      <= 5'd0;
            r_dv      <= 1'b0;
            r_si      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr_pend <= n_wr_pend;
            r_do_a    <= n_do_a;
            r_do_b    <= n_do_b;
            r_ri      <= n_ri;
            r_ci      <= n_ci;
            r_dv      <= n_dv;
            r_si      <= n_si;
            r_o_valid <= emit ? 1'b1 : (m_axis_tready ? 1'b0 : r_o_valid);
            if (acc) begin
                r_mode   <= n_mode;
                r_quote  <= n_quote;
                r_len    <= n_len;
                r_expect <= n_expect;
                r_ovf    <= n_ovf;
                r_kw     <= n_kw;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mem_kind  <= n_mem_kind;
        r_mem_len   <= n_mem_len;
        r_mem_trunc <= n_mem_trunc;
        r_a         <= n_a;
        r_b         <= n_b;
        if (acc && p_wr) begin
            r_wr_addr <= p_wr_addr;
            r_wr_data <= s_axis_tdata;
        end
        if (emit) begin
            r_out <= res;
        end
    end

    // text memory: write is held back while a token is read out
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            mem_text[r_wr_addr] <= r_wr_data;
        end
        if (rd_issue) begin
            r_rd_data <= mem_text[r_ri[stt_pkg::ADDR_W-1:0]];
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {1'b0, r_out.last, r_out.trunc, r_out.idx, r_out.chr};
    assign m_axis_tuser  = {r_out.cv, r_out.kind};
    assign m_axis_tlast  = r_out.lot;

    `STT_ASSERT_ALWAYS(a_len_in_cap, r_len <= CAP5, "token length beyond text capacity")
    `STT_ASSERT_SAME(a_readahead, r_dv, r_ci < r_mem_len, "read data held past token end")
    `STT_ASSERT_NEXT(a_last_to_idle, emit && res.last, r_state == stt_pkg::S_IDLE,
                     "sequencer busy after final beat of a byte")
    `STT_ASSERT_NEXT(a_wr_held, r_wr_pend && r_state == stt_pkg::S_MEM, r_wr_pend,
                     "text write dropped during token readout")

endmodule

[sim/tokenizer_checker.sv]
// ----------------------------------------------------------------------------
// tokenizer_checker
// watches both stream channels of the tokenizer, predicts the character beats
// of every accepted source byte and compares each output beat field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tokenizer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // in_byte
    input  logic        i_s_axis_tlast,   // end_of_input
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [15:0] i_m_axis_tdata,   // char_byte, char_index, token_truncated, last
    input  logic [4:0]  i_m_axis_tuser,   // token_kind, char_valid
    input  logic        i_m_axis_tlast,   // last_of_token
    output int          o_mismatches,
    output int          o_pending
);

    // lexer state as seen from outside
    stt_pkg::t_mode    scan_mode;
    logic [7:0]        quote_char;
    logic [7:0]        word_buf [31];
    int                word_len;
    logic              want_name;
    logic              word_cut;

    stt_pkg::t_result  char_beats_due [$];
    int                beats_this_step;
    int                error_count = 0;

    function automatic logic digit_char(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic letter_char(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic blank_char(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic txt_matches(input logic [7:0] txt [31], input int n,
                                         input string lit);
        int k;
        if (n != lit.len())
            return 1'b0;
        for (k = 0; k < n; k++)
            if (txt[k] != lit[k])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void show_beat(input string tag, input stt_pkg::t_result r);
        $display("  %s kind %0d chr %02h cv %0d idx %0d lot %0d trunc %0d last %0d", tag,
                 r.kind, r.chr, r.cv, r.idx, r.lot, r.trunc, r.last);
    endfunction

    // classification also updates the pending-declaration flag
    function automatic stt_pkg::t_kind kind_of_text(input logic [7:0] txt [31], input int n);
        logic all_num;
        int   k;
        all_num = (n > 0);
        for (k = 0; k < n; k++)
            if (!digit_char(txt[k]))
                all_num = 1'b0;
        if (txt_matches(txt, n, "+") || txt_matches(txt, n, "-") ||
            txt_matches(txt, n, "*") || txt_matches(txt, n, "/")) begin
            want_name = 1'b0;
            return stt_pkg::K_BINOP;
        end
        if (all_num) begin
            want_name = 1'b0;
            return stt_pkg::K_INT;
        end
        if (txt_matches(txt, n, "int") || txt_matches(txt, n, "string") ||
            txt_matches(txt, n, "bool")) begin
            want_name = 1'b1;
            return stt_pkg::K_KEYWORD;
        end
        if (want_name && n > 0 && letter_char(txt[0])) begin
            want_name = 1'b0;
            return stt_pkg::K_IDENT;
        end
        if (txt_matches(txt, n, "true") || txt_matches(txt, n, "false")) begin
            want_name = 1'b0;
            return stt_pkg::K_BOOL;
        end
        if (txt_matches(txt, n, "if")) begin
            want_name = 1'b0;
            return stt_pkg::K_IF;
        end
        if (txt_matches(txt, n, "(")) begin
            want_name = 1'b0;
            return stt_pkg::K_LPAREN;
        end
        if (txt_matches(txt, n, ")")) begin
            want_name = 1'b0;
            return stt_pkg::K_RPAREN;
        end
        if (txt_matches(txt, n, ";")) begin
            want_name = 1'b0;
            return stt_pkg::K_SEMI;
        end
        if (txt_matches(txt, n, "{"))
            return stt_pkg::K_LCURLY;
        if (txt_matches(txt, n, "}"))
            return stt_pkg::K_RCURLY;
        if (txt_matches(txt, n, "else"))
            return stt_pkg::K_ELSE;
        if (txt_matches(txt, n, "==") || txt_matches(txt, n, "<") || txt_matches(txt, n, ">"))
            return stt_pkg::K_COMPARE;
        return stt_pkg::K_IDENT;
    endfunction

    // one beat per character, or one empty beat for a token without text
    task automatic put_token(input stt_pkg::t_kind kind, input logic [7:0] txt [31],
                             input int n, input logic cut);
        stt_pkg::t_result r;
        int               total;
        int               i;
        total = (n == 0) ? 1 : n;
        for (i = 0; i < total; i++) begin
            if (beats_this_step >= 32)
                return;
            r.kind  = kind;
            r.chr   = (n == 0) ? 8'h00 : txt[i];
            r.cv    = (n != 0);
            r.idx   = 5'(i);
            r.lot   = (i + 1 == total);
            r.trunc = cut;
            r.last  = 1'b0;
            char_beats_due.push_back(r);
            beats_this_step++;
        end
    endtask

    task automatic open_run(input stt_pkg::t_mode m);
        scan_mode = m;
        word_len  = 0;
        word_cut  = 1'b0;
    endtask

    task automatic add_char(input logic [7:0] c);
        if (word_len < stt_pkg::TEXT_CAP && word_len < 31) begin
            word_buf[word_len] = c;
            word_len++;
        end else begin
            word_cut = 1'b1;
        end
    endtask

    task automatic flush_run();
        stt_pkg::t_kind k;
        k = kind_of_text(word_buf, word_len);
        put_token(k, word_buf, word_len, word_cut);
        open_run(stt_pkg::MODE_IDLE);
    endtask

    task automatic start_byte(input logic [7:0] c);
        logic [7:0]     one [31];
        stt_pkg::t_kind k;
        if (blank_char(c))
            return;
        if (digit_char(c)) begin
            open_run(stt_pkg::MODE_DIGITS);
            add_char(c);
            return;
        end
        if (letter_char(c)) begin
            open_run(stt_pkg::MODE_LETTERS);
            add_char(c);
            return;
        end
        if (c == stt_pkg::CH_EQ) begin
            open_run(stt_pkg::MODE_EQUAL);
            return;
        end
        if (c == stt_pkg::CH_SQUOTE || c == stt_pkg::CH_DQUOTE) begin
            open_run(stt_pkg::MODE_QUOTED);
            quote_char = c;
            return;
        end
        one[0] = c;
        k = kind_of_text(one, 1);
        put_token(k, one, 1, 1'b0);
    endtask

    task automatic predict_beat(input logic [7:0] c, input logic eoi);
        logic [7:0]       eq_txt [31];
        int               first;
        stt_pkg::t_result r;
        first           = char_beats_due.size();
        beats_this_step = 0;
        eq_txt[0]       = stt_pkg::CH_EQ;
        eq_txt[1]       = stt_pkg::CH_EQ;
        if (eoi) begin
            case (scan_mode)
                stt_pkg::MODE_DIGITS, stt_pkg::MODE_LETTERS: flush_run();
                stt_pkg::MODE_QUOTED: begin
                    // unterminated string still comes out as a string
                    want_name = 1'b0;
                    put_token(stt_pkg::K_STRING, word_buf, word_len, word_cut);
                end
                stt_pkg::MODE_EQUAL: put_token(stt_pkg::K_EQUALS, eq_txt, 1, 1'b0);
                default: ;
            endcase
            open_run(stt_pkg::MODE_IDLE);
            put_token(stt_pkg::K_END, eq_txt, 0, 1'b0);
        end else begin
            case (scan_mode)
                stt_pkg::MODE_DIGITS: begin
                    if (digit_char(c)) begin
                        add_char(c);
                    end else begin
                        flush_run();
                        start_byte(c);
                    end
                end
                stt_pkg::MODE_LETTERS: begin
                    if (letter_char(c)) begin
                        add_char(c);
                    end else begin
                        flush_run();
                        start_byte(c);
                    end
                end
                stt_pkg::MODE_QUOTED: begin
                    if (c == quote_char) begin
                        want_name = 1'b0;
                        put_token(stt_pkg::K_STRING, word_buf, word_len, word_cut);
                        open_run(stt_pkg::MODE_IDLE);
                    end else begin
                        add_char(c);
                    end
                end
                stt_pkg::MODE_EQUAL: begin
                    open_run(stt_pkg::MODE_IDLE);
                    if (c == stt_pkg::CH_EQ) begin
                        put_token(stt_pkg::K_COMPARE, eq_txt, 2, 1'b0);
                    end else begin
                        // lone equals, then the byte is scanned again
                        put_token(stt_pkg::K_EQUALS, eq_txt, 1, 1'b0);
                        start_byte(c);
                    end
                end
                default: begin
                    scan_mode = stt_pkg::MODE_IDLE;
                    start_byte(c);
                end
            endcase
        end
        if (char_beats_due.size() > first) begin
            r      = char_beats_due.pop_back();
            r.last = 1'b1;
            char_beats_due.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin : track
        stt_pkg::t_result seen;
        stt_pkg::t_result want;
        int               k;
        if (!i_rst_n) begin
            scan_mode  = stt_pkg::MODE_IDLE;
            quote_char = 8'h00;
            word_len   = 0;
            want_name  = 1'b0;
            word_cut   = 1'b0;
            for (k = 0; k < 31; k++)
                word_buf[k] = 8'h00;
            char_beats_due.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                predict_beat(i_s_axis_tdata, i_s_axis_tlast);
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                seen.kind  = stt_pkg::t_kind'(i_m_axis_tuser[3:0]);
                seen.cv    = i_m_axis_tuser[4];
                seen.chr   = i_m_axis_tdata[7:0];
                seen.idx   = i_m_axis_tdata[12:8];
                seen.trunc = i_m_axis_tdata[13];
                seen.last  = i_m_axis_tdata[14];
                seen.lot   = i_m_axis_tlast;
                if (char_beats_due.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: unexpected beat kind %0d chr %02h idx %0d", $time,
                                 seen.kind, seen.chr, seen.idx);
                end else begin
                    want = char_beats_due.pop_front();
                    if (seen.kind != want.kind || seen.chr != want.chr ||
                        seen.cv != want.cv || seen.idx != want.idx ||
                        seen.lot != want.lot || seen.trunc != want.trunc ||
                        seen.last != want.last) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("%0t: mismatch", $time);
                            show_beat("exp", want);
                            show_beat("got", seen);
                        end
                    end
                end
            end
        end
        o_pending    <= char_beats_due.size();
        o_mismatches <= error_count;
    end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// feeds source text to the tokenizer: a short directed program, then random
// token streams under three sender/receiver idling mixes and one long output
// stall; the checker beside the block predicts and compares every beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata   = 8'h00;   // in_byte
    logic        s_axis_tlast   = 1'b0;    // end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [15:0] m_axis_tdata;             // char_byte, char_index, token_truncated, last
    logic [4:0]  m_axis_tuser;             // token_kind, char_valid
    logic        m_axis_tlast;             // last_of_token

    int mismatch_count;
    int beats_outstanding;
    int send_idle_pct = 28;
    int recv_idle_pct = 58;
    int hold_requests = 0;
    int bytes_sent    = 0;

    source_text_tokenizer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    tokenizer_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tlast  (s_axis_tlast),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .i_m_axis_tlast  (m_axis_tlast),
        .o_mismatches    (mismatch_count),
        .o_pending       (beats_outstanding)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver: random ready, or a long counted hold-off when one is requested
    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = 300;
                m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic offer_beat(input logic [7:0] b, input logic eoi);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eoi;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic push_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            offer_beat(s[k], 1'b0);
    endtask

    task automatic push_end();
        offer_beat(8'($urandom_range(255)), 1'b1);
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = $urandom_range(1) ? "a" : "A";
        return base + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_blank();
        return ($urandom_range(5) == 0) ? 8'h20 : 8'($urandom_range(13, 9));
    endfunction

    function automatic string reserved_word(input int sel);
        case (sel)
            0:       return "int";
            1:       return "string";
            2:       return "bool";
            3:       return "true";
            4:       return "false";
            5:       return "if";
            default: return "else";
        endcase
    endfunction

    task automatic push_name(input int n);
        int k;
        for (k = 0; k < n; k++)
            offer_beat(rand_letter(), 1'b0);
    endtask

    task automatic push_number(input int n);
        int k;
        for (k = 0; k < n; k++)
            offer_beat(8'("0" + $urandom_range(9)), 1'b0);
    endtask

    task automatic push_quoted(input int n);
        logic [7:0] q;
        logic [7:0] ch;
        int         k;
        q = $urandom_range(1) ? 8'h22 : 8'h27;
        offer_beat(q, 1'b0);
        for (k = 0; k < n; k++) begin
            ch = 8'($urandom_range(255));
            while (ch == q)
                ch = 8'($urandom_range(255));
            offer_beat(ch, 1'b0);
        end
        offer_beat(q, 1'b0);
    endtask

    // one random lexical piece, mostly well-formed, sometimes noise or end
    task automatic send_fragment();
        string punct;
        int    pick;
        int    n;
        punct = "+-*/();{}<>";
        pick  = $urandom_range(99);
        if (pick < 14) begin
            push_text(reserved_word($urandom_range(2)));
            offer_beat(rand_blank(), 1'b0);
            push_name($urandom_range(6, 1));
        end else if (pick < 26) begin
            push_text(reserved_word($urandom_range(6)));
        end else if (pick < 40) begin
            push_name($urandom_range(6, 1));
        end else if (pick < 50) begin
            push_number($urandom_range(5, 1));
        end else if (pick < 60) begin
            push_quoted($urandom_range(6));
        end else if (pick < 72) begin
            offer_beat(punct[$urandom_range(punct.len() - 1)], 1'b0);
        end else if (pick < 80) begin
            if ($urandom_range(1))
                push_text("==");
            else
                push_text("=");
        end else if (pick < 85) begin
            // often past the text buffer, where the token comes out truncated
            n = $urandom_range(40, 29);
            case ($urandom_range(2))
                0:       push_name(n);
                1:       push_number(n);
                default: push_quoted(n);
            endcase
        end else if (pick < 92) begin
            offer_beat(8'($urandom_range(255)), 1'b0);
        end else if (pick < 96) begin
            offer_beat(rand_blank(), 1'b0);
        end else begin
            push_end();
        end
        if ($urandom_range(1))
            offer_beat(rand_blank(), 1'b0);
    endtask

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_text("int a=1;if(a==2){''}");
        offer_beat(8'h00, 1'b0);
        offer_beat(8'hFF, 1'b0);
        push_end();
        push_text("\"s");
        push_end();

        while (bytes_sent < 186)
            send_fragment();

        send_idle_pct = 58;
        recv_idle_pct = 28;
        while (bytes_sent < 346)
            send_fragment();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        push_name(35);
        offer_beat(8'h20, 1'b0);
        while (bytes_sent < 506)
            send_fragment();
        push_end();
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (beats_outstanding != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatch_count == 0 && beats_outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
